// ===== rtl/core/base32_grouped_encoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Base32 grouped encoder: assertion macros
// Shared concurrent assertion forms, sampled on clk_i, off while in reset.
// ----------------------------------------------------------------------------
`ifndef BASE32_GROUPED_ENCODER_TOP_ASSERT_SVH
`define BASE32_GROUPED_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define B32G_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define B32G_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/b32g_pkg.sv =====
// ----------------------------------------------------------------------------
// Base32 grouped encoder: package
// Job record, character codes and the symbol alphabet.
// ----------------------------------------------------------------------------
`default_nettype none

package b32g_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [6:0] CHAR_DASH = 7'h2D;  // '-'
  localparam logic [6:0] CHAR_PAD  = 7'h3D;  // '='
  localparam logic [6:0] CHAR_A    = 7'h41;  // 'A'
  localparam logic [6:0] CHAR_TWO  = 7'h32;  // '2'
  localparam logic [4:0] NUM_LETTERS = 5'd26;
  localparam logic [3:0] CHUNK_BITS  = 4'd5;

  // One byte's work: bit accumulator, valid bit count (8..12), final flag.
  typedef struct packed {
    logic [11:0] acc;
    logic [3:0]  cnt;
    logic        fin;
  } job_t;

  // A-Z then 2-7.
  function automatic logic [6:0] b32_symbol(input logic [4:0] idx);
    logic [6:0] ch;
    if (idx < NUM_LETTERS) begin
      ch = CHAR_A + {2'b00, idx};
    end else begin
      ch = CHAR_TWO + {2'b00, idx - NUM_LETTERS};
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/b32g_if.sv =====
// ----------------------------------------------------------------------------
// Base32 grouped encoder: channel interfaces
// Byte request channel and character request channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface b32g_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b32g_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       end_of_text;

  modport source (output valid, output out_char, output end_of_text, input ready);
  modport sink   (input valid, input out_char, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/base32_grouped_encoder_top.sv =====
// ----------------------------------------------------------------------------
// Base32 grouped encoder: top level
// Byte stream in, Base32 text out in dash-separated groups of eight.
// ----------------------------------------------------------------------------
//
//   channel     dir  payload                         request taken when
//   in_req_i    in   data_byte[7:0], final_byte      valid && ready
//   out_req_o   out  out_char[6:0], end_of_text      valid && ready
//
// The emitter sends one character per cycle unless the output stalls; a
//   byte yields its symbols plus a dash between groups, and a final byte
//   also its pads. Sustained rate is set by the single character port.
// Byte requests are taken while the two-entry job queue has room, so the
//   front end keeps accepting while the emitter or the output stalls.
// The output register holds a character until taken; the next one is
//   computed in the cycle it leaves.
// Reset (rst_ni, async, active low) clears leftover bits, group position,
//   the queue and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module base32_grouped_encoder_top import b32g_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  b32g_in_if.sink    in_req_i,
  b32g_out_if.source out_req_o
);

  // front -> queue
  logic push;
  job_t push_job;
  logic full;

  // queue -> emitter
  logic pop;
  logic head_valid;
  job_t head_job;

  // Front end: merges leftover bits with the new byte, one job per byte.
  b32g_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_req_i (in_req_i),
    .full_i   (full),
    .push_o   (push),
    .job_o    (push_job)
  );

  // Decouples byte intake from character emission.
  b32g_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  // Emitter: owns group position and the output register.
  b32g_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_req_o   (out_req_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/b32g_front.sv =====
// ----------------------------------------------------------------------------
// Base32 grouped encoder: front end
// Takes byte requests, merges leftover bits, pushes one job per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module b32g_front import b32g_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  b32g_in_if.sink    in_req_i,
  input  wire logic  full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [3:0] left_bits_q, left_bits_d;
  logic [2:0] left_cnt_q, left_cnt_d;
  logic [2:0] rem_cnt;
  logic [3:0] rem_mask;

  assign in_req_i.ready = !full_i;
  assign push_o         = in_req_i.valid && !full_i;

  always_comb begin
    job_o.acc = {left_bits_q, in_req_i.data_byte};
    job_o.cnt = {1'b0, left_cnt_q} + 4'd8;
    job_o.fin = in_req_i.final_byte;

    // Bits left over after taking whole 5-bit chunks.
    case (left_cnt_q)
      3'd0: begin rem_cnt = 3'd3; rem_mask = 4'b0111; end
      3'd1: begin rem_cnt = 3'd4; rem_mask = 4'b1111; end
      3'd2: begin rem_cnt = 3'd0; rem_mask = 4'b0000; end
      3'd3: begin rem_cnt = 3'd1; rem_mask = 4'b0001; end
      3'd4: begin rem_cnt = 3'd2; rem_mask = 4'b0011; end
      default: begin rem_cnt = 3'd0; rem_mask = 4'b0000; end
    endcase

    if (in_req_i.final_byte) begin
      left_bits_d = 4'd0;
      left_cnt_d  = 3'd0;
    end else begin
      left_bits_d = in_req_i.data_byte[3:0] & rem_mask;
      left_cnt_d  = rem_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_bits_q <= 4'd0;
      left_cnt_q  <= 3'd0;
    end else if (push_o) begin
      left_bits_q <= left_bits_d;
      left_cnt_q  <= left_cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b32g_fifo.sv =====
// ----------------------------------------------------------------------------
// Base32 grouped encoder: job queue
// Short FIFO between front end and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module b32g_fifo import b32g_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  job_t       job_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output job_t       job_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == DepthC);
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b32g_back.sv =====
// ----------------------------------------------------------------------------
// Base32 grouped encoder: emitter
// Walks one job a character per unstalled cycle: symbols, dashes, final pads.
// ----------------------------------------------------------------------------
`default_nettype none

module b32g_back import b32g_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  job_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  b32g_out_if.source out_req_o
);

  logic        busy_q;
  logic [11:0] acc_q;
  logic [3:0]  cnt_q, cnt_d;
  logic        fin_q;
  logic        dash_q, dash_d;
  logic [2:0]  gpos_q, gpos_d;
  logic        out_valid_q;
  logic [6:0]  out_char_q, char_d;
  logic        out_eot_q;

  logic [16:0] shifted;
  logic        more;
  logic        can_emit, step, finish;

  assign out_req_o.valid       = out_valid_q;
  assign out_req_o.out_char    = out_char_q;
  assign out_req_o.end_of_text = out_eot_q;

  assign can_emit = !out_valid_q || out_req_o.ready;
  assign step     = busy_q && can_emit;
  assign finish   = step && !more;
  assign pop_o    = job_valid_i && (!busy_q || finish);

  // Chunk below the current count; also zero-fills a short final chunk.
  assign shifted = {acc_q, 5'b00000} >> cnt_q;

  always_comb begin
    char_d = CHAR_PAD;
    cnt_d  = cnt_q;
    gpos_d = gpos_q;
    dash_d = 1'b0;
    more   = 1'b1;
    if (dash_q) begin
      char_d = CHAR_DASH;
      // a dash is the last character unless a whole chunk or a final tail remains
      more   = (cnt_q >= CHUNK_BITS) || (fin_q && cnt_q != 4'd0);
    end else if (cnt_q >= CHUNK_BITS) begin
      cnt_d  = cnt_q - CHUNK_BITS;
      char_d = b32_symbol(shifted[4:0]);
      gpos_d = gpos_q + 3'd1;
      dash_d = (gpos_d == 3'd0) && (!fin_q || cnt_d != 4'd0);
      more   = dash_d || (cnt_d >= CHUNK_BITS) ||
               (fin_q && (cnt_d != 4'd0 || gpos_d != 3'd0));
    end else if (cnt_q != 4'd0) begin
      // short final chunk
      cnt_d  = 4'd0;
      char_d = b32_symbol(shifted[4:0]);
      gpos_d = gpos_q + 3'd1;
      more   = (gpos_d != 3'd0);
    end else begin
      // pad up the group
      gpos_d = gpos_q + 3'd1;
      more   = (gpos_d != 3'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      dash_q      <= 1'b0;
      gpos_q      <= 3'd0;
      out_valid_q <= 1'b0;
      cnt_q       <= 4'd0;
      fin_q       <= 1'b0;
    end else begin
      if (step) begin
        gpos_q <= gpos_d;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
        cnt_q  <= job_i.cnt;
        fin_q  <= job_i.fin;
        dash_q <= 1'b0;
      end else if (finish) begin
        busy_q <= 1'b0;
      end else if (step) begin
        cnt_q  <= cnt_d;
        dash_q <= dash_d;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_req_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      acc_q <= job_i.acc;
    end
    if (step) begin
      out_char_q <= char_d;
      out_eot_q  <= fin_q && !more;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b32g_checker.sv =====
// ----------------------------------------------------------------------------
// Base32 grouped encoder: port checker
// Watches the character channel; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "base32_grouped_encoder_top_assert.svh"

module b32g_checker import b32g_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [6:0] out_char_i,
  input wire logic       out_eot_i
);

  logic out_fire;
  logic legal_char;

  assign out_fire   = out_valid_i && out_ready_i;
  assign legal_char = (out_char_i == CHAR_DASH) || (out_char_i == CHAR_PAD) ||
                      (out_char_i >= CHAR_A && out_char_i <= 7'h5A) ||
                      (out_char_i >= CHAR_TWO && out_char_i <= 7'h37);

  `B32G_ASSERT_NEXT(a_stall_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_char_i) && $stable(out_eot_i), "stalled character changed")
  `B32G_ASSERT_NOW(a_legal_char, out_fire, legal_char, "character outside alphabet")
  `B32G_ASSERT_NOW(a_no_dash_end, out_fire && out_eot_i, out_char_i != CHAR_DASH, "text ends on a dash")
  `B32G_ASSERT_NEXT(a_no_dash_twice, out_fire && out_char_i == CHAR_DASH, !(out_fire && out_char_i == CHAR_DASH), "two dashes in a row")

endmodule

bind base32_grouped_encoder_top b32g_checker u_b32g_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_req_o.valid),
  .out_ready_i (out_req_o.ready),
  .out_char_i  (out_req_o.out_char),
  .out_eot_i   (out_req_o.end_of_text)
);

`default_nettype wire
